### design/per_source_login_limiter_assert.svh
// Assertion macros shared by the checker of the per-source login limiter.
// Each macro expands to one labeled concurrent assertion on clk_i / rst_ni.
`ifndef PER_SOURCE_LOGIN_LIMITER_ASSERT_SVH
`define PER_SOURCE_LOGIN_LIMITER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define LLIM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LLIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/llim_pkg.sv
// Shared types and constants of the per-source login limiter.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package llim_pkg;

  // Table geometry and field widths
  localparam int unsigned TABLE_ENTRIES_DFLT = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned FAIL_W   = 4;
  localparam int unsigned BLEN_W   = 31;
  localparam int unsigned VERDICT_W = 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH  = 1'd1;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration reset values
  localparam logic [FAIL_W-1:0] FAILURE_LIMIT_RST = 4'd5;
  localparam logic [BLEN_W-1:0] BLOCK_LENGTH_RST  = 31'd60000;

  // Result codes
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ALLOWED       = 2'd0,
    VERDICT_STILL_BLOCKED = 2'd1,
    VERDICT_JUST_BLOCKED  = 2'd2,
    VERDICT_CHALLENGE     = 2'd3
  } verdict_e;

  // One table row as stored in memory
  typedef struct packed {
    logic [TIME_W-1:0] blocked_until;
    logic [FAIL_W-1:0] failures;
    logic [TIME_W-1:0] last_seen;
    logic [ADDR_W-1:0] address;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### design/per_source_login_limiter.sv
// Each accepted attempt is compared against the table from entry 0, one entry
// read per cycle, until a hit or the last entry; then the verdict is registered.
// No new item is taken before the last one's verdict is in the output register.
// A finished verdict waits in the output register while the next item is taken.
// Reset: asynchronous, active low; clears control, config to defaults and the
// per-entry valid bits, so every table entry reads as zero until written.
`timescale 1ns / 1ps
`default_nettype none

module per_source_login_limiter
  import llim_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DFLT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Attempt stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [63:0]           s_axis_tdata,   // [31:0] source_address, [63:32] now_ms
  input  wire logic                  s_axis_tuser,   // [0] credentials_ok
  // Verdict stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // [1:0] verdict, [7:2] zero
  // Configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  state_e              state_q, state_d;
  logic [FAIL_W-1:0]   limit_q, limit_d;
  logic [BLEN_W-1:0]   blen_q, blen_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic                ok_q, ok_d;
  logic [IDX_W-1:0]    ptr_q, ptr_d;
  logic [IDX_W-1:0]    ev_idx_q, ev_idx_d;
  logic                issued_q, issued_d;
  logic                vld_rd_q, vld_rd_d;
  logic [IDX_W-1:0]    cand_q, cand_d;
  logic [TIME_W-1:0]   cand_ls_q, cand_ls_d;
  logic [IDX_W-1:0]    slot_q, slot_d;
  logic [FAIL_W-1:0]   ent_fail_q, ent_fail_d;
  logic [TIME_W-1:0]   ent_until_q, ent_until_d;
  logic                out_vld_q, out_vld_d;
  verdict_e            verdict_q, verdict_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  logic                in_acc;
  logic                ram_re;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_ent;
  entry_t              wr_ent;
  logic                hit;
  logic                take_cand;
  logic [IDX_W-1:0]    cand_nx;
  logic [TIME_W-1:0]   cand_ls_nx;
  logic                out_free;
  logic [TIME_W-1:0]   diff;
  logic                blocked;
  logic [FAIL_W:0]     fail_inc;
  logic [TIME_W-1:0]   new_until;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, verdict_q};
  assign out_free      = !out_vld_q || m_axis_tready;

  // Entry never written reads as all zero
  assign rd_ent = vld_rd_q ? entry_t'(ram_rdata) : '0;

  // Scan compare and replacement candidate for the entry just read
  assign hit       = (rd_ent.address == addr_q);
  assign take_cand = (ev_idx_q == '0) || (rd_ent.last_seen == '0) ||
                     (rd_ent.last_seen < cand_ls_q);
  assign cand_nx    = take_cand ? ev_idx_q : cand_q;
  assign cand_ls_nx = take_cand ? rd_ent.last_seen : cand_ls_q;

  // Verdict arithmetic on the held entry
  assign diff      = ent_until_q - now_q;
  assign blocked   = (ent_until_q != '0) && (diff != '0) && !diff[TIME_W-1];
  assign fail_inc  = {1'b0, ent_fail_q} + (FAIL_W+1)'(1);
  assign new_until = now_q + {1'b0, blen_q};

  assign ram_re = (state_q == ST_SCAN);
  assign ram_we = (state_q == ST_UPDATE) && out_free;

  always_comb begin
    state_d     = state_q;
    limit_d     = limit_q;
    blen_d      = blen_q;
    addr_d      = addr_q;
    now_d       = now_q;
    ok_d        = ok_q;
    ptr_d       = ptr_q;
    ev_idx_d    = ev_idx_q;
    issued_d    = issued_q;
    vld_rd_d    = vld_rd_q;
    cand_d      = cand_q;
    cand_ls_d   = cand_ls_q;
    slot_d      = slot_q;
    ent_fail_d  = ent_fail_q;
    ent_until_d = ent_until_q;
    out_vld_d   = out_vld_q;
    verdict_d   = verdict_q;
    valid_d     = valid_q;
    wr_ent      = '0;

    // Drop the verdict once taken
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    // Configuration writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FAILURE_LIMIT: limit_d = cfg_data_i[FAIL_W-1:0];
        REG_BLOCK_LENGTH:  blen_d  = cfg_data_i[BLEN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          addr_d   = s_axis_tdata[31:0];
          now_d    = s_axis_tdata[63:32];
          ok_d     = s_axis_tuser;
          ptr_d    = '0;
          issued_d = 1'b0;
          state_d  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue the next read, one entry per cycle
        vld_rd_d = valid_q[ptr_q];
        ev_idx_d = ptr_q;
        ptr_d    = (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
        issued_d = 1'b1;

        // Evaluate the entry read in the previous cycle
        if (issued_q) begin
          cand_d    = cand_nx;
          cand_ls_d = cand_ls_nx;
          if (hit) begin
            slot_d      = ev_idx_q;
            ent_fail_d  = rd_ent.failures;
            ent_until_d = rd_ent.blocked_until;
            state_d     = ST_UPDATE;
          end else if (ev_idx_q == LAST_IDX) begin
            slot_d      = cand_nx;
            ent_fail_d  = '0;
            ent_until_d = '0;
            state_d     = ST_UPDATE;
          end
        end
      end

      ST_UPDATE: begin
        wr_ent.address       = addr_q;
        wr_ent.last_seen     = now_q;
        wr_ent.failures      = ent_fail_q;
        wr_ent.blocked_until = ent_until_q;
        if (blocked) begin
          verdict_d = VERDICT_STILL_BLOCKED;
        end else if (ok_q) begin
          wr_ent.failures      = '0;
          wr_ent.blocked_until = '0;
          verdict_d            = VERDICT_ALLOWED;
        end else if (fail_inc >= {1'b0, limit_q}) begin
          wr_ent.failures      = '0;
          wr_ent.blocked_until = new_until;
          verdict_d            = VERDICT_JUST_BLOCKED;
        end else begin
          wr_ent.failures = fail_inc[FAIL_W-1:0];
          verdict_d       = VERDICT_CHALLENGE;
        end
        // Hold until the output register is free
        if (out_free) begin
          valid_d[slot_q] = 1'b1;
          out_vld_d       = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          verdict_d = verdict_q;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= FAILURE_LIMIT_RST;
      blen_q      <= BLOCK_LENGTH_RST;
      addr_q      <= '0;
      now_q       <= '0;
      ok_q        <= 1'b0;
      ptr_q       <= '0;
      ev_idx_q    <= '0;
      issued_q    <= 1'b0;
      vld_rd_q    <= 1'b0;
      cand_q      <= '0;
      cand_ls_q   <= '0;
      slot_q      <= '0;
      ent_fail_q  <= '0;
      ent_until_q <= '0;
      out_vld_q   <= 1'b0;
      verdict_q   <= VERDICT_ALLOWED;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      blen_q      <= blen_d;
      addr_q      <= addr_d;
      now_q       <= now_d;
      ok_q        <= ok_d;
      ptr_q       <= ptr_d;
      ev_idx_q    <= ev_idx_d;
      issued_q    <= issued_d;
      vld_rd_q    <= vld_rd_d;
      cand_q      <= cand_d;
      cand_ls_q   <= cand_ls_d;
      slot_q      <= slot_d;
      ent_fail_q  <= ent_fail_d;
      ent_until_q <= ent_until_d;
      out_vld_q   <= out_vld_d;
      verdict_q   <= verdict_d;
      valid_q     <= valid_d;
    end
  end

  // Source table
  llim_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

### design/llim_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the source table of the login limiter.
`timescale 1ns / 1ps
`default_nettype none

module llim_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### design/llim_checker.sv
// Port-level checker for the per-source login limiter, bound to the top level.
// Depends on llim_pkg and the assertion macros in per_source_login_limiter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "per_source_login_limiter_assert.svh"

module llim_checker
  import llim_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [7:0]            m_axis_tdata    // [1:0] verdict, [7:2] zero
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A stalled verdict holds its value
  `LLIM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata), "verdict changed while stalled")

  // Padding bits above the verdict stay zero
  `LLIM_ASSERT_SAME(a_out_pad, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0,
                    "nonzero padding in verdict beat")

  // One attempt at a time: input closes after a beat
  `LLIM_ASSERT_NEXT(a_busy_after_beat, in_beat, !s_axis_tready,
                    "input ready right after an accepted beat")

  // A scan and an update precede each verdict, so none appears right after a beat
  `LLIM_ASSERT_NEXT(a_no_instant_verdict, in_beat, !$rose(m_axis_tvalid),
                    "verdict appeared one cycle after accept")

endmodule

bind per_source_login_limiter llim_checker u_llim_checker (.*);

`default_nettype wire
